// ===== rtl/core/bbm_pkg.sv =====
// Shared constants and types for the multichannel band-pass biquad.
package bbm_pkg;

   localparam int SAMPLE_W     = 16;
   localparam int CHAN_W       = 3;
   localparam int COEF_W       = 18;
   localparam int STATE_W      = 24;
   localparam int FRAC_W       = 16;
   localparam int DIFF_W       = STATE_W + 1;
   localparam int PROD_W       = COEF_W + DIFF_W;
   localparam int ACC_W        = PROD_W + 1;
   localparam int CHANNELS_DEF = 8;
   localparam int CSR_IDX_W    = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_COEF_B0 = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_COEF_A1 = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_COEF_A2 = 2'd2;

   typedef enum logic [2:0] {
      STEP_HOLD,
      STEP_FB1,
      STEP_FB2,
      STEP_STATE,
      STEP_FF
   } step_type;

   typedef struct packed {
      step_type step;
      logic     state_valid;
   } ctrl_type;

endpackage

// ===== rtl/core/bbm_if.sv =====
// Request and response channel interfaces.
interface bbm_req_if;
   import bbm_pkg::*;
   logic                       valid;
   logic                       ready;
   logic signed [SAMPLE_W-1:0] sample_in;
   logic        [CHAN_W-1:0]   channel;
   modport source (output valid, sample_in, channel, input ready);
   modport sink (input valid, sample_in, channel, output ready);
endinterface

interface bbm_rsp_if;
   import bbm_pkg::*;
   logic                       valid;
   logic                       ready;
   logic signed [SAMPLE_W-1:0] sample_out;
   logic        [CHAN_W-1:0]   channel_out;
   modport source (output valid, sample_out, channel_out, input ready);
   modport sink (input valid, sample_out, channel_out, output ready);
endinterface

// ===== rtl/core/biquad_bandpass_multichannel.sv =====
// Top level: multichannel band-pass biquad, direct form II.
// Steps per request: FB1, FB2, STATE, FF, OUT; a channel out of range skips to OUT.
// The shared datapath takes a new request only once the last one has left OUT.
// A response waiting in the output register does not block the next request.
// Reset (synchronous): clears coefficients, sequencer, response valid and state valid flags.
module biquad_bandpass_multichannel #(
   parameter int CHANNELS = bbm_pkg::CHANNELS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   bbm_req_if.sink                             req,
   bbm_rsp_if.source                           rsp,
   input  logic                                csr_wr_en,
   input  logic [bbm_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [bbm_pkg::COEF_W-1:0]          csr_wdata
);
   import bbm_pkg::*;

   localparam int AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

   typedef enum logic [2:0] {
      S_IDLE,
      S_FB1,
      S_FB2,
      S_STATE,
      S_FF,
      S_OUT
   } state_type;

   state_type                  state_ff;
   logic signed [COEF_W-1:0]   b0_ff, a1_ff, a2_ff;
   logic [CHANNELS-1:0]        valid_ff;
   logic [AW-1:0]              addr_ff, req_addr;
   logic [AW+CHAN_W-1:0]       chan_ext;
   logic [CHAN_W-1:0]          chan_ff;
   logic signed [SAMPLE_W-1:0] x_ff;
   logic                       range_ff, req_range;
   logic                       rsp_valid_ff;
   logic signed [SAMPLE_W-1:0] rsp_sample_ff;
   logic [CHAN_W-1:0]          rsp_chan_ff;
   logic                       accept, rsp_load, ram_wr;
   logic [2*STATE_W-1:0]       ram_rd_data, ram_wr_data;
   logic signed [SAMPLE_W-1:0] result;
   ctrl_type                   ctrl;

   assign req.ready = (state_ff == S_IDLE);
   assign accept    = req.valid && req.ready;
   assign chan_ext  = (AW + CHAN_W)'(req.channel);
   assign req_addr  = chan_ext[AW-1:0];
   assign req_range = int'(req.channel) < CHANNELS;
   assign rsp_load  = (state_ff == S_OUT) && (!rsp_valid_ff || rsp.ready);
   assign ram_wr    = (state_ff == S_FF) && range_ff;

   always_comb begin
      ctrl.state_valid = valid_ff[addr_ff];
      case (state_ff)
         S_FB1:   ctrl.step = STEP_FB1;
         S_FB2:   ctrl.step = STEP_FB2;
         S_STATE: ctrl.step = STEP_STATE;
         S_FF:    ctrl.step = STEP_FF;
         default: ctrl.step = STEP_HOLD;
      endcase
   end

   bbm_ram #(
      .WIDTH (2 * STATE_W),
      .DEPTH (CHANNELS)
   ) u_state_ram (
      .clock   (clock),
      .wr_en   (ram_wr),
      .wr_addr (addr_ff),
      .wr_data (ram_wr_data),
      .rd_en   (accept),
      .rd_addr (req_addr),
      .rd_data (ram_rd_data)
   );

   bbm_datapath u_datapath (
      .clock   (clock),
      .ctrl    (ctrl),
      .coef_b0 (b0_ff),
      .coef_a1 (a1_ff),
      .coef_a2 (a2_ff),
      .sample  (x_ff),
      .rd_data (ram_rd_data),
      .wr_data (ram_wr_data),
      .result  (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         b0_ff        <= '0;
         a1_ff        <= '0;
         a2_ff        <= '0;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               CSR_COEF_B0: b0_ff <= csr_wdata;
               CSR_COEF_A1: a1_ff <= csr_wdata;
               CSR_COEF_A2: a2_ff <= csr_wdata;
               default: begin
               end
            endcase
         end
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (ram_wr) begin
            valid_ff[addr_ff] <= 1'b1;
         end
         case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  state_ff <= req_range ? S_FB1 : S_OUT;
               end
            end
            S_FB1:   state_ff <= S_FB2;
            S_FB2:   state_ff <= S_STATE;
            S_STATE: state_ff <= S_FF;
            S_FF:    state_ff <= S_OUT;
            S_OUT: begin
               if (rsp_load) begin
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
      if (accept) begin
         addr_ff  <= req_addr;
         chan_ff  <= req.channel;
         x_ff     <= req.sample_in;
         range_ff <= req_range;
      end
      if (rsp_load) begin
         rsp_sample_ff <= range_ff ? result : '0;
         rsp_chan_ff   <= chan_ff;
      end
   end

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.sample_out  = rsp_sample_ff;
   assign rsp.channel_out = rsp_chan_ff;

   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      accept |=> !req.ready)
      else $error("request accepted while an item is in flight");

   a_write_in_range: assert property (@(posedge clock) disable iff (reset)
      ram_wr |-> (int'(chan_ff) < CHANNELS))
      else $error("state write for a channel out of range");

   a_valid_after_write: assert property (@(posedge clock) disable iff (reset)
      ram_wr |=> valid_ff[$past(addr_ff)])
      else $error("state entry not marked valid after write");

   a_zero_out_of_range: assert property (@(posedge clock) disable iff (reset)
      (rsp_load && !range_ff) |=> (rsp.sample_out == '0))
      else $error("nonzero response for channel out of range");

   a_load_sets_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_load |=> rsp.valid && (rsp.channel_out == $past(chan_ff)))
      else $error("response register not loaded");

endmodule

// ===== rtl/core/bbm_ram.sv =====
// Generic single-port-write, registered-read RAM.
module bbm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/bbm_datapath.sv =====
// Shared multiplier, accumulator and rounding/saturation for the biquad.
module bbm_datapath (
   input  logic                                clock,
   input  bbm_pkg::ctrl_type                   ctrl,
   input  logic signed [bbm_pkg::COEF_W-1:0]   coef_b0,
   input  logic signed [bbm_pkg::COEF_W-1:0]   coef_a1,
   input  logic signed [bbm_pkg::COEF_W-1:0]   coef_a2,
   input  logic signed [bbm_pkg::SAMPLE_W-1:0] sample,
   input  logic [2*bbm_pkg::STATE_W-1:0]       rd_data,
   output logic [2*bbm_pkg::STATE_W-1:0]       wr_data,
   output logic signed [bbm_pkg::SAMPLE_W-1:0] result
);
   import bbm_pkg::*;

   function automatic logic signed [STATE_W-1:0] sat_state(input logic signed [ACC_W-1:0] v);
      logic signed [ACC_W-1:0]        r;
      logic signed [ACC_W-FRAC_W-1:0] s;
      r = v + ACC_W'(1 << (FRAC_W - 1));
      s = (ACC_W-FRAC_W)'(r >>> FRAC_W);
      if (s[ACC_W-FRAC_W-1:STATE_W-1] == '0 || s[ACC_W-FRAC_W-1:STATE_W-1] == '1) begin
         return s[STATE_W-1:0];
      end
      return s[ACC_W-FRAC_W-1] ? {1'b1, {(STATE_W-1){1'b0}}} : {1'b0, {(STATE_W-1){1'b1}}};
   endfunction

   function automatic logic signed [SAMPLE_W-1:0] sat_out(input logic signed [PROD_W-1:0] v);
      logic signed [ACC_W-1:0]        r;
      logic signed [ACC_W-FRAC_W-1:0] s;
      r = ACC_W'(v) + ACC_W'(1 << (FRAC_W - 1));
      s = (ACC_W-FRAC_W)'(r >>> FRAC_W);
      if (s[ACC_W-FRAC_W-1:SAMPLE_W-1] == '0 || s[ACC_W-FRAC_W-1:SAMPLE_W-1] == '1) begin
         return s[SAMPLE_W-1:0];
      end
      return s[ACC_W-FRAC_W-1] ? {1'b1, {(SAMPLE_W-1){1'b0}}} : {1'b0, {(SAMPLE_W-1){1'b1}}};
   endfunction

   logic signed [STATE_W-1:0] w1_ff, w1_in, w2_ff, w2_in, w_ff, w_in;
   logic signed [ACC_W-1:0]   acc_ff, acc_in, acc_next;
   logic signed [PROD_W-1:0]  prod_ff, prod_in;
   logic signed [STATE_W-1:0] w1_src, w2_src;
   logic signed [COEF_W-1:0]  mul_a;
   logic signed [DIFF_W-1:0]  mul_b, diff;

   assign w1_src   = ctrl.state_valid ? rd_data[2*STATE_W-1:STATE_W] : '0;
   assign w2_src   = ctrl.state_valid ? rd_data[STATE_W-1:0] : '0;
   assign diff     = {w_ff[STATE_W-1], w_ff} - {w2_ff[STATE_W-1], w2_ff};
   assign acc_next = acc_ff - {prod_ff[PROD_W-1], prod_ff};

   always_comb begin
      mul_a  = '0;
      mul_b  = '0;
      w1_in  = w1_ff;
      w2_in  = w2_ff;
      w_in   = w_ff;
      acc_in = acc_ff;
      case (ctrl.step)
         STEP_FB1: begin
            mul_a  = coef_a1;
            mul_b  = {w1_src[STATE_W-1], w1_src};
            w1_in  = w1_src;
            w2_in  = w2_src;
            acc_in = {{(ACC_W-SAMPLE_W-FRAC_W){sample[SAMPLE_W-1]}}, sample, {FRAC_W{1'b0}}};
         end
         STEP_FB2: begin
            mul_a  = coef_a2;
            mul_b  = {w2_ff[STATE_W-1], w2_ff};
            acc_in = acc_next;
         end
         STEP_STATE: begin
            w_in = sat_state(acc_next);
         end
         STEP_FF: begin
            mul_a = coef_b0;
            mul_b = diff;
         end
         default: begin
         end
      endcase
      prod_in = PROD_W'(mul_a * mul_b);
      // keep the output product while the response waits
      if (ctrl.step == STEP_HOLD) begin
         prod_in = prod_ff;
      end
   end

   always_ff @(posedge clock) begin
      w1_ff   <= w1_in;
      w2_ff   <= w2_in;
      w_ff    <= w_in;
      acc_ff  <= acc_in;
      prod_ff <= prod_in;
   end

   assign wr_data = {w_ff, w1_ff};
   assign result  = sat_out(prod_ff);

endmodule
